/* hw/rtl/ptcc_pkg.sv */
// ============================================================================
// ptcc_pkg: shared types and constants for the traffic class counter
// Holds the request and result payload types, mode and kind codes.
// ============================================================================
package ptcc_pkg;

    localparam logic [1:0] MODE_PACKET = 2'd0;
    localparam logic [1:0] MODE_TCP_WR = 2'd1;
    localparam logic [1:0] MODE_UDP_WR = 2'd2;
    localparam logic [1:0] MODE_FLUSH  = 2'd3;

    localparam logic [1:0] PROTO_TCP = 2'd1;
    localparam logic [1:0] PROTO_UDP = 2'd2;

    localparam logic [1:0] KIND_NETFLOW = 2'd1;
    localparam logic [1:0] KIND_SFLOW   = 2'd2;

    localparam logic [3:0] UNMAPPED       = 4'd15;
    localparam logic [3:0] USER_CLASS_CAP = 4'd14;

    localparam logic [0:0] REG_USER_CLASSES = 1'b0;
    localparam logic [0:0] REG_INTERVAL     = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] pkt_length;
        logic [1:0]  record_kind;
        logic [31:0] flow_pkt_count;
        logic [31:0] sample_factor;
        logic [31:0] arrival_seconds;
        logic [15:0] entry_port;
        logic [3:0]  entry_class;
    } req_t;

    typedef struct packed {
        logic [31:0] interval_start;
        logic [3:0]  class_index;
        logic [63:0] bytes_rate;
        logic [31:0] pkts_rate;
        logic        last;
    } res_t;

    // Control between sequencer and shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [15:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

/* hw/rtl/ptcc_stream_if.sv */
// ============================================================================
// ptcc_stream_if: valid/ready channel
// Carries one payload of a parametric type between a source and a sink.
// ============================================================================
interface ptcc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ptcc_divider.sv */
// ============================================================================
// ptcc_divider: shared restoring divider
// Divides a 64-bit value by a 16-bit value, one quotient bit per cycle.
// ============================================================================
module ptcc_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptcc_pkg::div_cmd_t    cmd,
    output ptcc_pkg::div_rsp_t    rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] div_reg;
    logic        done_reg;

    logic [16:0] shifted;
    logic [16:0] trial;

    assign shifted = {rem_reg[15:0], quo_reg[63]};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
            div_reg <= (cmd.divisor == 16'd0) ? 16'd1 : cmd.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> busy_reg) else $error("divider did not start");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !cmd.start |=> rem_reg < {1'b0, div_reg})
        else $error("remainder out of range");

endmodule

/* hw/rtl/port_based_traffic_class_counter_top.sv */
// ============================================================================
// port_based_traffic_class_counter_top: port-based traffic class counter
// Maps packets to classes through TCP/UDP port tables, accumulates per-class
// byte and packet counts, and reports per-class rates on a flush request.
// ============================================================================
// Sequence: a table write completes while the block stays idle; a packet
// request reads both port tables, forms the products (a second product step
// for a NetFlow record) and updates the counters. A flush walks the classes
// in turn, the shared divider giving the byte and then the packet rate for
// each, and may wait on the result channel. After reset the port tables are
// swept to "unmapped" entry by entry; no request is accepted during that pass.
module port_based_traffic_class_counter_top #(
    parameter int PORT_SPACE  = 65536,
    parameter int CLASS_COUNT = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ptcc_stream_if.sink          req,
    ptcc_stream_if.source        res,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int PW = $clog2(PORT_SPACE);
    localparam int CW = $clog2(CLASS_COUNT);

    // Highest number of user classes that the counters can hold.
    localparam logic [3:0] CLASS_TOP = 4'(CLASS_COUNT - 2);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD_SRC = 4'd2;
    localparam logic [3:0] S_RD_DST = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_FL_RD  = 4'd7;
    localparam logic [3:0] S_FL_DB  = 4'd8;
    localparam logic [3:0] S_FL_DP  = 4'd9;
    localparam logic [3:0] S_FL_OUT = 4'd10;
    localparam logic [3:0] S_FL_WB  = 4'd11;

    logic [3:0]  state_reg;
    logic [3:0]  user_classes_reg;
    logic [15:0] interval_reg;

    ptcc_pkg::req_t req_reg;
    ptcc_pkg::res_t res_reg;
    logic           res_valid_reg;

    // Port tables: one memory each, swept to unmapped after reset.
    logic [3:0]  tcp_mem [PORT_SPACE];
    logic [3:0]  udp_mem [PORT_SPACE];
    logic [PW:0] clr_reg;
    logic [3:0]  tcp_rd_reg;
    logic [3:0]  udp_rd_reg;
    logic        rd_hit_reg;
    logic [3:0]  cls_a_reg;

    // Counters live in registers with fixed per-class ports plus one update.
    logic [63:0] byte_cnt_reg [CLASS_COUNT];
    logic [31:0] pkt_cnt_reg  [CLASS_COUNT];
    logic [31:0] ts_reg;
    logic        open_reg;

    logic [CW-1:0] cls_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   add_b_reg;
    logic [31:0]   add_p_reg;
    logic [63:0]   rate_b_reg;
    logic [31:0]   rate_p_reg;

    ptcc_pkg::div_cmd_t div_cmd;
    ptcc_pkg::div_rsp_t div_rsp;

    logic [3:0]  uc;
    logic [3:0]  entry_cls;
    logic [3:0]  min_cls;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        req_fire;
    logic        wr_ok;
    logic [15:0] rd_port;
    logic        rd_hit;
    logic        load_res;

    assign uc = (user_classes_reg > CLASS_TOP) ? CLASS_TOP : user_classes_reg;
    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // A new result is loaded only once the output register is free.
    assign load_res = (state_reg == S_FL_OUT) && (!res_valid_reg || res.ready);

    // Clamp a table entry against the classes in use. A port outside the
    // table reads as unmapped.
    always_comb
    begin
        entry_cls = (req_reg.protocol == ptcc_pkg::PROTO_TCP) ? tcp_rd_reg : udp_rd_reg;
        if (!rd_hit_reg || entry_cls >= uc)
        begin
            entry_cls = uc;
        end
        min_cls = (entry_cls < cls_a_reg) ? entry_cls : cls_a_reg;
    end

    // The shared 32x32 multiplier (S_MUL2 forms one more 16x16 product beside it).
    always_comb
    begin
        mul_a = req_reg.flow_pkt_count;
        mul_b = {16'd0, req_reg.sample_factor[15:0]};
        if (state_reg == S_MUL2)
        begin
            mul_a = {16'd0, req_reg.pkt_length};
            mul_b = prod_reg[31:0];
        end
        else if (req_reg.record_kind == ptcc_pkg::KIND_SFLOW)
        begin
            mul_a = {16'd0, req_reg.pkt_length};
            mul_b = req_reg.sample_factor;
        end
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    assign wr_ok   = ({16'd0, req.data.entry_port} < 32'(PORT_SPACE));
    assign rd_port = (state_reg == S_RD_SRC) ? req_reg.sport : req_reg.dport;
    assign rd_hit  = ({16'd0, rd_port} < 32'(PORT_SPACE));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            tcp_mem[clr_reg[PW-1:0]] <= ptcc_pkg::UNMAPPED;
            udp_mem[clr_reg[PW-1:0]] <= ptcc_pkg::UNMAPPED;
        end
        else if (req_fire && wr_ok && req.data.mode == ptcc_pkg::MODE_TCP_WR)
        begin
            tcp_mem[req.data.entry_port[PW-1:0]] <= req.data.entry_class;
        end
        else if (req_fire && wr_ok && req.data.mode == ptcc_pkg::MODE_UDP_WR)
        begin
            udp_mem[req.data.entry_port[PW-1:0]] <= req.data.entry_class;
        end
        tcp_rd_reg <= tcp_mem[rd_port[PW-1:0]];
        udp_rd_reg <= udp_mem[rd_port[PW-1:0]];
        rd_hit_reg <= rd_hit;
    end

    ptcc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_cmd.start    = 1'b0;
        div_cmd.divisor  = interval_reg;
        div_cmd.dividend = byte_cnt_reg[cls_reg];
        if (state_reg == S_FL_RD)
        begin
            div_cmd.start = 1'b1;
        end
        else if (state_reg == S_FL_DB && div_rsp.done)
        begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {32'd0, pkt_cnt_reg[cls_reg]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            user_classes_reg <= '0;
            interval_reg     <= 16'd1;
            res_valid_reg    <= 1'b0;
            open_reg         <= 1'b0;
            ts_reg           <= '0;
            cls_reg          <= '0;
            byte_cnt_reg     <= '{default: '0};
            pkt_cnt_reg      <= '{default: '0};
        end
        else
        begin
            if (cfg_we && cfg_index == ptcc_pkg::REG_USER_CLASSES)
            begin
                user_classes_reg <= cfg_data[3:0];
            end
            else if (cfg_we && cfg_index == ptcc_pkg::REG_INTERVAL)
            begin
                interval_reg <= cfg_data;
            end
            if (res.valid && res.ready && !load_res)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + (PW+1)'(1);
                    if (clr_reg == (PW+1)'(PORT_SPACE - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        req_reg <= req.data;
                        cls_reg <= '0;
                        if (req.data.mode == ptcc_pkg::MODE_PACKET)
                        begin
                            state_reg <= S_RD_SRC;
                            if (!open_reg)
                            begin
                                open_reg     <= 1'b1;
                                ts_reg       <= req.data.arrival_seconds;
                                byte_cnt_reg <= '{default: '0};
                                pkt_cnt_reg  <= '{default: '0};
                            end
                        end
                        else if (req.data.mode == ptcc_pkg::MODE_FLUSH)
                        begin
                            state_reg <= S_FL_RD;
                        end
                    end
                end
                S_RD_SRC:
                begin
                    state_reg <= S_RD_DST;
                end
                S_RD_DST:
                begin
                    // Source entry is in the read register now.
                    cls_a_reg <= entry_cls;
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    if (req_reg.protocol == ptcc_pkg::PROTO_TCP ||
                        req_reg.protocol == ptcc_pkg::PROTO_UDP)
                    begin
                        cls_reg <= min_cls[CW-1:0];
                    end
                    else
                    begin
                        cls_reg <= CW'(uc + 4'd1);
                    end
                    prod_reg <= mul_p;
                    if (req_reg.record_kind == ptcc_pkg::KIND_NETFLOW)
                    begin
                        state_reg <= S_MUL2;
                    end
                    else if (req_reg.record_kind == ptcc_pkg::KIND_SFLOW)
                    begin
                        add_b_reg <= mul_p;
                        add_p_reg <= req_reg.sample_factor;
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        add_b_reg <= {48'd0, req_reg.pkt_length};
                        add_p_reg <= 32'd1;
                        state_reg <= S_ACC;
                    end
                end
                S_MUL2:
                begin
                    // count*samp is below 2^48; the high part times length
                    // only reaches bits 32 and up.
                    add_b_reg <= mul_p + {32'(prod_reg[47:32]) * 32'(req_reg.pkt_length),
                                          32'd0};
                    add_p_reg <= prod_reg[31:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    byte_cnt_reg[cls_reg] <= byte_cnt_reg[cls_reg] + add_b_reg;
                    pkt_cnt_reg[cls_reg]  <= pkt_cnt_reg[cls_reg] + add_p_reg;
                    state_reg <= S_IDLE;
                end
                S_FL_RD:
                begin
                    state_reg <= S_FL_DB;
                end
                S_FL_DB:
                begin
                    if (div_rsp.done)
                    begin
                        rate_b_reg <= div_rsp.quotient;
                        state_reg  <= S_FL_DP;
                    end
                end
                S_FL_DP:
                begin
                    if (div_rsp.done)
                    begin
                        rate_p_reg <= div_rsp.quotient[31:0];
                        state_reg  <= S_FL_OUT;
                    end
                end
                S_FL_OUT:
                begin
                    // The previous result may still be waiting; it is
                    // replaced only in the cycle that it is taken.
                    if (load_res)
                    begin
                        res_reg.interval_start <= ts_reg;
                        res_reg.class_index    <= 4'(cls_reg);
                        res_reg.bytes_rate     <= rate_b_reg;
                        res_reg.pkts_rate      <= rate_p_reg;
                        res_reg.last           <= (4'(cls_reg) == uc + 4'd1);
                        res_valid_reg          <= 1'b1;
                        state_reg              <= S_FL_WB;
                    end
                end
                S_FL_WB:
                begin
                    if (res_reg.last)
                    begin
                        open_reg     <= 1'b0;
                        byte_cnt_reg <= '{default: '0};
                        pkt_cnt_reg  <= '{default: '0};
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        cls_reg   <= cls_reg + CW'(1);
                        state_reg <= S_FL_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready) else $error("accepted while busy");
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> 4'(cls_reg) <= uc + 4'd1) else $error("class out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> $stable(res_reg))
        else $error("result changed while waiting");

endmodule
